>>> hdl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg: shared types and constants of the gate region rasterizer
// Field widths, opcodes, register map, reset values and the control and
// status groups between the sequencer and the multiply-divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

  // item fields
  localparam int OP_W   = 2;
  localparam int PIX_W  = 10;

  // configuration fields
  localparam int GRID_W = 11;
  localparam int PPM_W  = 8;
  localparam int CW_W   = 12;
  localparam int HC_W   = CW_W + PPM_W;

  // line position: sign plus magnitude saturated at 2^LINE_SAT_BIT
  localparam int LINE_SAT_BIT = 40;
  localparam int LINE_W       = LINE_SAT_BIT + 2;

  // APB register file
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [OP_W-1:0] OP_OBS   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PPM         = 2'd2;
  localparam logic [1:0] REG_CW          = 2'd3;

  localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = 11'd400;
  localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = 11'd400;
  localparam logic [PPM_W-1:0]  PPM_RST         = 8'd23;
  localparam logic [CW_W-1:0]   CW_RST          = 12'd256;

  // raster sides above this act as this
  localparam logic [GRID_W-1:0] MAX_SIDE = 11'd1024;

  typedef struct packed {
    logic start;
    logic neg;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

`default_nettype wire

>>> hdl/grr_muldiv.sv
// ----------------------------------------------------------------------------
// grr_muldiv: bit-serial multiply then divide
// Computes sign * sat(trunc(((a * b) >> SH) / d)), one bit per cycle:
// shift-add multiply over the BW multiplier bits, restoring divide over the quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_muldiv #(
  parameter int AW = 24,
  parameter int BW = 21,
  parameter int DW = 27,
  parameter int SH = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  grr_pkg::md_ctrl_t                   ctrl,
  input  logic [AW-1:0]                       a_mag,
  input  logic [BW-1:0]                       b_mag,
  input  logic [DW-1:0]                       d_mag,
  output grr_pkg::md_stat_t                   stat,
  output logic signed [grr_pkg::LINE_W-1:0]   line
);
  import grr_pkg::*;

  localparam int PW   = AW + BW;
  localparam int QW   = PW - SH;
  localparam int NW   = (BW > QW) ? BW : QW;
  localparam int CNTW = $clog2(NW + 1);
  localparam int QX   = (QW > LINE_SAT_BIT + 1) ? QW : LINE_SAT_BIT + 1;
  localparam logic [QX-1:0] SAT_X = {{(QX-1){1'b0}}, 1'b1} << LINE_SAT_BIT;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} md_state_t;

  md_state_t        state;
  logic [CNTW-1:0]  cnt;
  logic [PW-1:0]    acc;
  logic [AW-1:0]    mcand;
  logic [BW-1:0]    mplier;
  logic [DW-1:0]    dvs;
  logic [QW-1:0]    quo;
  logic [DW-1:0]    rem;
  logic             neg;
  logic             done;

  logic [PW-1:0]           acc_step;
  logic [DW:0]             rem_sh;
  logic [DW:0]             rem_dif;
  logic                    rem_ge;
  logic [QX-1:0]           q_x;
  logic [QX-1:0]           q_cap;
  logic signed [LINE_W-1:0] q_ext;
  logic signed [LINE_W-1:0] line_next;

  assign acc_step = {acc[PW-2:0], 1'b0} + (mplier[BW-1] ? PW'(mcand) : '0);
  assign rem_sh   = {rem, quo[QW-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvs};
  assign rem_dif  = rem_sh - {1'b0, dvs};

  assign q_x       = QX'(quo);
  assign q_cap     = (q_x > SAT_X) ? SAT_X : q_x;
  assign q_ext     = $signed({1'b0, q_cap[LINE_SAT_BIT:0]});
  assign line_next = neg ? -q_ext : q_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == MD_FIN);
      case (state)
        MD_IDLE: begin
          if (ctrl.start) begin
            mcand  <= a_mag;
            mplier <= b_mag;
            dvs    <= d_mag;
            neg    <= ctrl.neg;
            acc    <= '0;
            cnt    <= CNTW'(BW);
            state  <= MD_MUL;
          end
        end
        MD_MUL: begin
          acc    <= acc_step;
          mplier <= mplier << 1;
          if (cnt == CNTW'(1)) begin
            // drop the scale bits of the product on the way into the divider
            quo   <= acc_step[PW-1:SH];
            rem   <= '0;
            cnt   <= CNTW'(QW);
            state <= MD_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        MD_DIV: begin
          rem <= rem_ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
          quo <= {quo[QW-2:0], rem_ge};
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= MD_FIN;
          end
        end
        MD_FIN: begin
          line  <= line_next;
          state <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != MD_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

>>> hdl/gate_region_rasterizer.sv
// ----------------------------------------------------------------------------
// gate_region_rasterizer: gate and turn masks from the two farthest posts
// Tracks the farthest obstacle on each side and answers pixel mask queries.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall is high from accept until the item
// is done. An obstacle beat computes three squares on the shared
// multiplier, then the post update; a clear beat resets the posts at
// accept. A query with both posts present and the pixel inside the
// raster, above its bottom row, sends both lines in turn through one
// bit-serial multiply-divide unit. Queries with a post missing, or with
// the pixel outside the raster or on its bottom row, go straight to the
// result. A finished result waits in the output register while the next
// beat is taken.
`default_nettype none

module gate_region_rasterizer #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [grr_pkg::APB_AW-1:0]     paddr,
  input  logic [grr_pkg::APB_DW-1:0]     pwdata,
  output logic [grr_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  // input beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [grr_pkg::OP_W-1:0]       op,
  input  logic signed [COORD_BITS-1:0]   obs_x,
  input  logic signed [COORD_BITS-1:0]   obs_y,
  input  logic signed [COORD_BITS-1:0]   obs_z,
  input  logic [grr_pkg::PIX_W-1:0]      pixel_row,
  input  logic [grr_pkg::PIX_W-1:0]      pixel_col,
  // result beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           in_gate,
  output logic                           in_left_turn,
  output logic                           in_right_turn,
  output logic                           region_valid
);
  import grr_pkg::*;

  localparam int S      = FRAC_BITS + 1;
  localparam int MW     = (COORD_BITS > CW_W) ? COORD_BITS : CW_W;
  localparam int PRW    = 2 * MW;
  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int AW     = COORD_BITS + 8;
  localparam int BMW    = (((PIX_W + S) > HC_W) ? (PIX_W + S) : HC_W) + 1;
  localparam int BSW    = BMW + 1;
  localparam int DMW    = ((AW > HC_W) ? AW : HC_W) + 1;
  localparam int DSW    = DMW + 1;
  localparam int YW     = PIX_W + 2;
  localparam int EW     = LINE_W + 1 + S;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_POST, ST_HC, ST_BX, ST_BY, ST_START, ST_WAIT, ST_EVAL, ST_DONE
  } state_t;

  // configuration registers
  logic [GRID_W-1:0] grid_width;
  logic [GRID_W-1:0] grid_height;
  logic [PPM_W-1:0]  ppm;
  logic [CW_W-1:0]   cw_q8;

  // posts
  logic signed [COORD_BITS-1:0] left_post_x, left_post_y;
  logic signed [COORD_BITS-1:0] right_post_x, right_post_y;
  logic [DIST_W-1:0]            left_post_dist, right_post_dist;
  logic                         left_post_seen, right_post_seen;

  // sequencer
  state_t                       state;
  logic [1:0]                   sq_cnt;
  logic signed [COORD_BITS-1:0] ox, oy, oz;
  logic [DIST_W-1:0]            dist_acc;
  logic [GRID_W-1:0]            x_pix;
  logic signed [YW-1:0]         y_pix;
  logic [HC_W-1:0]              hc;
  logic                         side;     // 0 left, 1 right
  logic [AW-1:0]                bx_mag, by_mag;
  logic                         bx_neg, by_neg;
  logic signed [LINE_W-1:0]     line_r;
  logic                         ge_l;
  logic                         r_gate, r_lt, r_rt, r_valid;

  // shared multiplier
  logic signed [COORD_BITS-1:0] mul_src;
  logic [COORD_BITS-1:0]        mag_src;
  logic [MW-1:0]                mul_a, mul_b;
  logic [PRW-1:0]               mul_out;

  // query setup
  logic [GRID_W-1:0]    w_eff, h_eff;
  logic                 outside, bottom;
  logic [GRID_W-1:0]    x_calc;
  logic signed [YW-1:0] y_calc;

  // line setup
  logic signed [BSW-1:0] y_sh, hc_b, b_s, b_neg_v;
  logic [BMW-1:0]        b_mag;
  logic signed [DSW-1:0] by_ext, by_s, hc_d, div_s, div_neg_v;
  logic                  div_zero;
  logic [DMW-1:0]        d_mag;
  logic                  line_neg;

  // evaluation
  logic signed [LINE_W:0]  x_l, ln_l, diff;
  logic signed [EW-1:0]    diff_sh, lim_s;
  logic [HC_W+1:0]         hc3, hc_band;
  logic                    ge, band;

  md_ctrl_t                md_ctrl;
  md_stat_t                md_stat;
  logic signed [LINE_W-1:0] md_line;

  logic cfg_wr;
  logic in_acc;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      ppm         <= PPM_RST;
      cw_q8       <= CW_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GRID_WIDTH:  grid_width  <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[GRID_W-1:0];
        REG_PPM:         ppm         <= pwdata[PPM_W-1:0];
        REG_CW:          cw_q8       <= pwdata[CW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_WIDTH:  prdata = APB_DW'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DW'(grid_height);
      REG_PPM:         prdata = APB_DW'(ppm);
      REG_CW:          prdata = APB_DW'(cw_q8);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared multiplier
  // --------------------------------------------------------------------------
  always_comb begin
    case (state)
      ST_SQ:   mul_src = (sq_cnt == 2'd0) ? ox : ((sq_cnt == 2'd1) ? oy : oz);
      ST_BX:   mul_src = side ? right_post_x : left_post_x;
      ST_BY:   mul_src = side ? right_post_y : left_post_y;
      default: mul_src = ox;
    endcase
  end

  assign mag_src = mul_src[COORD_BITS-1] ? COORD_BITS'(-mul_src) : COORD_BITS'(mul_src);

  always_comb begin
    case (state)
      ST_SQ: begin
        mul_a = MW'(mag_src);
        mul_b = MW'(mag_src);
      end
      ST_HC: begin
        mul_a = MW'(cw_q8);
        mul_b = MW'(ppm);
      end
      ST_BX, ST_BY: begin
        mul_a = MW'(mag_src);
        mul_b = MW'(ppm);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // query setup at accept
  // --------------------------------------------------------------------------
  assign w_eff   = (grid_width > MAX_SIDE) ? MAX_SIDE : grid_width;
  assign h_eff   = (grid_height > MAX_SIDE) ? MAX_SIDE : grid_height;
  assign outside = ({1'b0, pixel_row} >= h_eff) || ({1'b0, pixel_col} >= w_eff);
  assign x_calc  = h_eff - {1'b0, pixel_row} - GRID_W'(1);
  assign bottom  = (x_calc == '0);
  assign y_calc  = $signed({2'b00, w_eff[GRID_W-1:1]}) - $signed({2'b00, pixel_col});

  // --------------------------------------------------------------------------
  // line setup: corner at +hc (left) or -hc (right)
  // --------------------------------------------------------------------------
  assign y_sh    = $signed({{(BSW-YW){y_pix[YW-1]}}, y_pix}) <<< S;
  assign hc_b    = $signed({{(BSW-HC_W){1'b0}}, hc});
  assign b_s     = side ? (y_sh + hc_b) : (y_sh - hc_b);
  assign b_neg_v = -b_s;
  assign b_mag   = b_s[BSW-1] ? b_neg_v[BMW-1:0] : b_s[BMW-1:0];

  assign by_ext    = $signed({{(DSW-AW){1'b0}}, by_mag});
  assign by_s      = by_neg ? -by_ext : by_ext;
  assign hc_d      = $signed({{(DSW-HC_W){1'b0}}, hc});
  assign div_s     = side ? (by_s + hc_d) : (by_s - hc_d);
  assign div_neg_v = -div_s;
  assign div_zero  = (div_s == '0);
  // post level with the corner: divide by one pixel
  assign d_mag     = div_zero ? (DMW'(1) << S)
                   : (div_s[DSW-1] ? div_neg_v[DMW-1:0] : div_s[DMW-1:0]);
  assign line_neg  = bx_neg ^ b_s[BSW-1] ^ div_s[DSW-1];

  assign md_ctrl.start = (state == ST_START);
  assign md_ctrl.neg   = line_neg;

  grr_muldiv #(
    .AW (AW),
    .BW (BMW),
    .DW (DMW),
    .SH (S)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (md_ctrl),
    .a_mag (bx_mag),
    .b_mag (b_mag),
    .d_mag (d_mag),
    .stat  (md_stat),
    .line  (md_line)
  );

  // --------------------------------------------------------------------------
  // evaluation of one line against the pixel
  // --------------------------------------------------------------------------
  assign x_l     = $signed({{(LINE_W+1-GRID_W){1'b0}}, x_pix});
  assign ln_l    = $signed({line_r[LINE_W-1], line_r});
  assign ge      = x_l >= ln_l;
  assign diff    = x_l - ln_l;
  assign diff_sh = $signed({{S{diff[LINE_W]}}, diff}) <<< S;
  assign hc3     = {2'b00, hc} + {1'b0, hc, 1'b0};
  assign hc_band = side ? hc3 : {2'b00, hc};
  assign lim_s   = $signed((EW'(h_eff[GRID_W-1:1]) << S) + EW'(hc_band));
  assign band    = diff_sh <= lim_s;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      sq_cnt          <= '0;
      side            <= 1'b0;
      left_post_x     <= '0;
      left_post_y     <= '0;
      left_post_dist  <= '0;
      left_post_seen  <= 1'b0;
      right_post_x    <= '0;
      right_post_y    <= '0;
      right_post_dist <= '0;
      right_post_seen <= 1'b0;
    end else begin
      // ST_DONE loads the next result beat itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (op)
              OP_OBS: begin
                ox       <= obs_x;
                oy       <= obs_y;
                oz       <= obs_z;
                dist_acc <= '0;
                sq_cnt   <= '0;
                state    <= ST_SQ;
              end
              OP_QUERY: begin
                r_gate <= 1'b0;
                r_lt   <= 1'b0;
                r_rt   <= 1'b0;
                side   <= 1'b0;
                x_pix  <= x_calc;
                y_pix  <= y_calc;
                if (!(left_post_seen && right_post_seen)) begin
                  r_valid <= 1'b0;
                  state   <= ST_DONE;
                end else begin
                  r_valid <= 1'b1;
                  state   <= (outside || bottom) ? ST_DONE : ST_HC;
                end
              end
              OP_CLEAR: begin
                left_post_x     <= '0;
                left_post_y     <= '0;
                left_post_dist  <= '0;
                left_post_seen  <= 1'b0;
                right_post_x    <= '0;
                right_post_y    <= '0;
                right_post_dist <= '0;
                right_post_seen <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SQ: begin
          dist_acc <= dist_acc + DIST_W'(mul_out[2*COORD_BITS-1:0]);
          sq_cnt   <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd2) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          // strict compare: on a tie the earlier post stays
          if (oy > 0) begin
            if (!left_post_seen || dist_acc > left_post_dist) begin
              left_post_x    <= ox;
              left_post_y    <= oy;
              left_post_dist <= dist_acc;
              left_post_seen <= 1'b1;
            end
          end else begin
            if (!right_post_seen || dist_acc > right_post_dist) begin
              right_post_x    <= ox;
              right_post_y    <= oy;
              right_post_dist <= dist_acc;
              right_post_seen <= 1'b1;
            end
          end
          state <= ST_IDLE;
        end
        ST_HC: begin
          hc    <= mul_out[HC_W-1:0];
          state <= ST_BX;
        end
        ST_BX: begin
          bx_mag <= {mul_out[COORD_BITS+6:0], 1'b0};
          bx_neg <= mul_src[COORD_BITS-1];
          state  <= ST_BY;
        end
        ST_BY: begin
          by_mag <= {mul_out[COORD_BITS+6:0], 1'b0};
          by_neg <= mul_src[COORD_BITS-1];
          state  <= ST_START;
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (md_stat.done) begin
            line_r <= md_line;
            state  <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!side) begin
            ge_l  <= ge;
            r_lt  <= ge && band;
            side  <= 1'b1;
            state <= ST_BX;
          end else begin
            r_rt   <= ge && band;
            r_gate <= ge_l && ge;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            in_gate       <= r_gate;
            in_left_turn  <= r_lt;
            in_right_turn <= r_rt;
            region_valid  <= r_valid;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_in_wait : assert property (@(posedge clk) disable iff (rst)
    md_stat.done |-> state == ST_WAIT)
    else $error("muldiv finished outside of the wait state");

  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    state == ST_START |-> !md_stat.busy)
    else $error("muldiv started while busy");

  a_no_mask_invalid : assert property (@(posedge clk) disable iff (rst)
    out_valid && !region_valid |-> !in_gate && !in_left_turn && !in_right_turn)
    else $error("mask bit set without both posts");

  a_missing_post : assert property (@(posedge clk) disable iff (rst)
    in_acc && op == OP_QUERY && !(left_post_seen && right_post_seen)
    |=> state == ST_DONE && !r_valid)
    else $error("query without posts did not short-cut");

endmodule

`default_nettype wire
